>>> design/sti_pkg.sv
// sti_pkg: shared codes, field widths and the cell control struct
// for the sorted table block; no dependencies
`default_nettype none

package sti_pkg;

  // payload field widths
  localparam int OPCODE_W = 3;
  localparam int IN_KEY_W = 32;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;

  // operation codes
  localparam logic [OPCODE_W-1:0] OP_APPEND     = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_INSERT     = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_INSERT_UNQ = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_DEL_KEY    = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_DEL_POS    = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DUP  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd3;

  // control broadcast to every cell of the row
  typedef struct packed {
    logic cmp_en;      // capture compare flags against the item key
    logic signed_cmp;  // two's complement ordering
    logic ins_en;      // commit an append or insert
    logic del_en;      // commit a delete, closing the gap
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> design/sti_if.sv
// sti_if: handshake channels of the sorted table block (item, result, config)
// depends on sti_pkg for the payload widths
`default_nettype none

interface sti_in_if import sti_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [IN_KEY_W-1:0] key;
  logic [POS_W-1:0]    position;

  modport source (output valid, opcode, key, position, input ready);
  modport sink   (input valid, opcode, key, position, output ready);
endinterface

interface sti_out_if import sti_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, status, entry_count, input ready);
  modport sink   (input valid, status, entry_count, output ready);
endinterface

interface sti_cfg_if ();
  logic valid;
  logic ready;
  logic signed_compare;

  modport source (output valid, signed_compare, input ready);
  modport sink   (input valid, signed_compare, output ready);
endinterface

`default_nettype wire

>>> design/sti_cell.sv
// sti_cell: one table entry; compares its key with the item key and
// takes its own key, the item key, or its left or right neighbour's on update; uses sti_pkg
`default_nettype none

module sti_cell import sti_pkg::*; #(
  parameter int KEY_WIDTH = 32
) (
  input  wire logic                 clk,
  input  wire cell_ctl_t            ctl,
  input  wire logic [KEY_WIDTH-1:0] key_in,
  input  wire logic [KEY_WIDTH-1:0] left_key,
  input  wire logic [KEY_WIDTH-1:0] right_key,
  input  wire logic                 ahead,
  input  wire logic                 hit,
  output logic      [KEY_WIDTH-1:0] key_q,
  output logic                      lt_q,
  output logic                      eq_q
);

  logic [KEY_WIDTH-1:0] key_r;
  logic [KEY_WIDTH-1:0] key_nxt;
  logic                 lt_r;
  logic                 eq_r;
  logic [KEY_WIDTH-1:0] top_m;
  logic [KEY_WIDTH-1:0] ord_own;
  logic [KEY_WIDTH-1:0] ord_in;

  // signed order: flip the sign bit so an unsigned compare suffices
  assign top_m   = KEY_WIDTH'(ctl.signed_cmp) << (KEY_WIDTH - 1);
  assign ord_own = key_r ^ top_m;
  assign ord_in  = key_in ^ top_m;

  // next key: shift up on insert, shift down on delete
  always_comb begin
    key_nxt = key_r;
    if (ctl.ins_en) begin
      if (ahead) begin
        key_nxt = left_key;
      end else if (hit) begin
        key_nxt = key_in;
      end
    end else if (ctl.del_en && (ahead || hit)) begin
      key_nxt = right_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    if (ctl.cmp_en) begin
      lt_r <= (ord_own < ord_in);
      eq_r <= (ord_own == ord_in);
    end
  end

  assign key_q = key_r;
  assign lt_q  = lt_r;
  assign eq_q  = eq_r;

endmodule

`default_nettype wire

>>> design/sti_prefix.sv
// sti_prefix: log-depth prefix OR over the cell hit flags, giving for each
// cell whether an earlier cell hit; no dependencies
`default_nettype none

module sti_prefix #(
  parameter int N = 32
) (
  input  wire logic [N-1:0] hit,
  output logic      [N-1:0] earlier
);

  localparam int LV = (N > 1) ? $clog2(N) : 1;

  logic [N-1:0] lvl [0:LV];

  assign lvl[0] = hit;

  // each level folds in the flags 2^(k-1) cells further back
  for (genvar k = 1; k <= LV; k++) begin : g_lvl
    for (genvar i = 0; i < N; i++) begin : g_bit
      if (i >= (1 << (k - 1))) begin : g_or
        assign lvl[k][i] = lvl[k-1][i] | lvl[k-1][i - (1 << (k - 1))];
      end else begin : g_pass
        assign lvl[k][i] = lvl[k-1][i];
      end
    end
  end

  // exclusive prefix: shift the inclusive result by one cell
  if (N > 1) begin : g_excl
    assign earlier = {lvl[LV][N-2:0], 1'b0};
  end else begin : g_one
    assign earlier = 1'b0;
  end

endmodule

`default_nettype wire

>>> design/sorted_table_insert_delete_top.sv
// sorted_table_insert_delete_top: row of key cells plus control, count and
// result register; depends on sti_pkg, sti_if, sti_cell and sti_prefix
`default_nettype none

// Sorted key table of up to CAPACITY keys held in a row of cells, one key per
// cell, with a count of valid entries. Each beat on in_bus carries an opcode
// (append, insert sorted, insert sorted unique, delete key, delete position),
// a key and a position; each yields one beat on out_bus with a status and the
// new count. An item goes in order: the beat is captured, then every cell
// registers its compare against the key, then a prefix OR over the cell flags
// picks the target cell and, if the item succeeds, the cells from it onward
// shift by one place in the update. A new beat is taken once the previous
// update is done; the result register holds the answer until out_bus takes it,
// stalling the update and so the next beat. cfg_bus.signed_compare selects
// two's complement ordering; write it while the block is idle. There is no
// clearing pass: entries beyond the count are never read.

module sorted_table_insert_delete_top import sti_pkg::*; #(
  parameter int CAPACITY  = 32,
  parameter int KEY_WIDTH = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sti_in_if.sink     in_bus,
  sti_out_if.source  out_bus,
  sti_cfg_if.sink    cfg_bus
);

  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [OPCODE_W-1:0]  op_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [POS_W-1:0]     pos_r;
  logic [CW-1:0]        count_r, count_nxt;
  logic                 signed_r;
  logic                 out_valid_r;
  logic [STATUS_W-1:0]  status_r;
  logic [CW-1:0]        out_count_r;
  logic [KEY_WIDTH-1:0] key_ext;

  logic [KEY_WIDTH-1:0] cell_key [0:CAPACITY-1];
  logic [CAPACITY-1:0]  lt_v, eq_v, valid_v, hit_v, before_v, dup_v;
  logic [31:0]          pos_ext;
  cell_ctl_t            ctl;
  logic                 upd_fire, full, any_hit, dup, is_ins, is_del;
  logic [STATUS_W-1:0]  status_nxt;

  // item key cut or zero-extended to the table key width
  if (KEY_WIDTH <= IN_KEY_W) begin : g_key_cut
    assign key_ext = in_bus.key[KEY_WIDTH-1:0];
  end else begin : g_key_ext
    assign key_ext = {{(KEY_WIDTH - IN_KEY_W){1'b0}}, in_bus.key};
  end

  assign pos_ext = {{(32 - POS_W){1'b0}}, pos_r};

  // handshakes
  assign in_bus.ready  = (state_r == S_IDLE);
  assign cfg_bus.ready = 1'b1;
  assign upd_fire      = (state_r == S_UPD) && (!out_valid_r || out_bus.ready);

  // per-cell target flags for the current opcode
  for (genvar i = 0; i < CAPACITY; i++) begin : g_flag
    logic at_end;
    assign valid_v[i] = (CW'(i) < count_r);
    assign at_end     = (CW'(i) == count_r);
    always_comb begin
      unique case (op_r)
        OP_APPEND:                hit_v[i] = at_end;
        OP_INSERT, OP_INSERT_UNQ: hit_v[i] = (valid_v[i] && !lt_v[i]) || at_end;
        OP_DEL_KEY:               hit_v[i] = valid_v[i] && eq_v[i];
        OP_DEL_POS:               hit_v[i] = valid_v[i] && (pos_ext == 32'(i));
        default:                  hit_v[i] = 1'b0;
      endcase
    end
    // equal key sitting at the insert point
    assign dup_v[i] = hit_v[i] && !before_v[i] && eq_v[i] && valid_v[i];
  end

  sti_prefix #(.N(CAPACITY)) u_prefix (
    .hit     (hit_v),
    .earlier (before_v)
  );

  assign full    = (count_r >= CW'(CAPACITY));
  assign any_hit = |hit_v;
  assign dup     = |dup_v;

  // status of the item in the update cycle
  always_comb begin
    unique case (op_r)
      OP_APPEND, OP_INSERT: status_nxt = full ? ST_FULL : ST_DONE;
      OP_INSERT_UNQ:        status_nxt = full ? ST_FULL : (dup ? ST_DUP : ST_DONE);
      OP_DEL_KEY, OP_DEL_POS: status_nxt = any_hit ? ST_DONE : ST_MISS;
      default:              status_nxt = ST_MISS;
    endcase
  end

  assign is_ins = (op_r == OP_APPEND) || (op_r == OP_INSERT) || (op_r == OP_INSERT_UNQ);
  assign is_del = (op_r == OP_DEL_KEY) || (op_r == OP_DEL_POS);

  // control broadcast to the row
  always_comb begin
    ctl.cmp_en     = (state_r == S_CMP);
    ctl.signed_cmp = signed_r;
    ctl.ins_en     = upd_fire && is_ins && (status_nxt == ST_DONE);
    ctl.del_en     = upd_fire && is_del && (status_nxt == ST_DONE);
  end

  // row of cells, each fed by its neighbours
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_WIDTH-1:0] left_k, right_k;
    if (i == 0) begin : g_first
      assign left_k = '0;
    end else begin : g_left
      assign left_k = cell_key[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_k = '0;
    end else begin : g_right
      assign right_k = cell_key[i+1];
    end
    sti_cell #(.KEY_WIDTH(KEY_WIDTH)) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .key_in    (key_r),
      .left_key  (left_k),
      .right_key (right_k),
      .ahead     (before_v[i]),
      .hit       (hit_v[i]),
      .key_q     (cell_key[i]),
      .lt_q      (lt_v[i]),
      .eq_q      (eq_v[i])
    );
  end

  // count update
  always_comb begin
    count_nxt = count_r;
    if (ctl.ins_en) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.del_en) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_bus.valid) state_nxt = S_CMP;
      S_CMP:   state_nxt = S_UPD;
      S_UPD:   if (upd_fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      signed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_bus.valid) begin
        signed_r <= cfg_bus.signed_compare;
      end
      if (upd_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item capture and result payload
  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      op_r  <= in_bus.opcode;
      key_r <= key_ext;
      pos_r <= in_bus.position;
    end
    if (upd_fire) begin
      status_r <= status_nxt;
    end
  end

  assign out_bus.valid  = out_valid_r;
  assign out_bus.status = status_r;

  // count reported modulo 64, held with the status beat
  always_ff @(posedge clk) begin
    if (upd_fire) begin
      out_count_r <= count_nxt;
    end
  end

  if (CW >= COUNT_W) begin : g_cnt_cut
    assign out_bus.entry_count = out_count_r[COUNT_W-1:0];
  end else begin : g_cnt_ext
    assign out_bus.entry_count = {{(COUNT_W - CW){1'b0}}, out_count_r};
  end

endmodule

`default_nettype wire

>>> dv/testbench.sv
// testbench: checks sorted_table_insert_delete_top against a shadow key table
// kept in step with every accepted beat; depends on sti_pkg and sti_if
// directed beats first, then random fill and drain runs under both orderings

module testbench;
  import sti_pkg::*;

  localparam int TABLE_DEPTH  = 32;
  localparam int PHASE_ITEMS  = 450;
  localparam int RUN_LENGTH   = 60;
  localparam int HOLD_AT      = 700;
  localparam int HOLD_CYCLES  = 200;
  localparam int SETTLE       = 6;
  localparam int WATCHDOG_MAX = 3000;

  // spare opcodes that the block must ignore
  localparam logic [OPCODE_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [IN_KEY_W-1:0] key;
    logic [POS_W-1:0]    position;
  } table_op_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  entry_count;
  } table_answer_t;

  logic clk;
  logic rst_n;

  sti_in_if  in_bus ();
  sti_out_if out_bus ();
  sti_cfg_if cfg_bus ();

  sorted_table_insert_delete_top DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  // shadow of the block state
  logic [IN_KEY_W-1:0] shadow_keys [TABLE_DEPTH];
  int                  shadow_count = 0;
  bit                  sign_mode = 1'b0;

  table_op_t     op_queue [$];
  table_answer_t pending_answers [$];
  table_answer_t want;

  int mismatch_count = 0;
  int results_seen   = 0;
  int in_gap_left    = 0;
  int out_stall_left = 0;
  int hold_left      = 0;
  int idle_cycles    = 0;
  bit quiet_tail     = 1'b0;

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // key as an unsigned ordering value under the current compare mode
  function automatic logic [IN_KEY_W-1:0] order_of(logic [IN_KEY_W-1:0] k);
    return k ^ {sign_mode, {(IN_KEY_W-1){1'b0}}};
  endfunction

  // applies one operation to the shadow table, returns status and count
  function automatic table_answer_t apply_table_op(table_op_t op);
    table_answer_t ans;
    int idx;
    int gone;
    ans.status = ST_MISS;
    gone = -1;
    case (op.opcode)
      OP_APPEND: begin
        if (shadow_count >= TABLE_DEPTH) begin
          ans.status = ST_FULL;
        end else begin
          shadow_keys[shadow_count] = op.key;
          shadow_count++;
          ans.status = ST_DONE;
        end
      end
      OP_INSERT, OP_INSERT_UNQ: begin
        if (shadow_count >= TABLE_DEPTH) begin
          ans.status = ST_FULL;
        end else begin
          idx = 0;
          while (idx < shadow_count && order_of(shadow_keys[idx]) < order_of(op.key))
            idx++;
          if (op.opcode == OP_INSERT_UNQ && idx < shadow_count &&
              shadow_keys[idx] == op.key) begin
            ans.status = ST_DUP;
          end else begin
            for (int j = shadow_count; j > idx; j--)
              shadow_keys[j] = shadow_keys[j-1];
            shadow_keys[idx] = op.key;
            shadow_count++;
            ans.status = ST_DONE;
          end
        end
      end
      OP_DEL_KEY: begin
        idx = 0;
        while (idx < shadow_count && shadow_keys[idx] != op.key)
          idx++;
        if (idx < shadow_count)
          gone = idx;
      end
      OP_DEL_POS: begin
        if (int'(op.position) < shadow_count)
          gone = int'(op.position);
      end
      default: ans.status = ST_MISS;
    endcase
    // close the gap left by a delete
    if (gone >= 0) begin
      for (int j = gone; j + 1 < shadow_count; j++)
        shadow_keys[j] = shadow_keys[j+1];
      shadow_count--;
      ans.status = ST_DONE;
    end
    ans.entry_count = shadow_count[COUNT_W-1:0];
    return ans;
  endfunction

  // item driver: holds a beat until taken, random gaps between beats
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid    <= 1'b0;
      in_bus.opcode   <= OP_APPEND;
      in_bus.key      <= '0;
      in_bus.position <= '0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        pending_answers.push_back(apply_table_op({in_bus.opcode, in_bus.key,
                                                  in_bus.position}));
        void'(op_queue.pop_front());
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (in_gap_left > 0) begin
          in_gap_left--;
          in_bus.valid <= 1'b0;
        end else if (op_queue.size() != 0) begin
          if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            in_gap_left  = $urandom_range(1, 6) - 1;
            in_bus.valid <= 1'b0;
          end else begin
            in_bus.valid    <= 1'b1;
            in_bus.opcode   <= op_queue[0].opcode;
            in_bus.key      <= op_queue[0].key;
            in_bus.position <= op_queue[0].position;
          end
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: compares each beat with the oldest answer, stalls at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        results_seen++;
        // one long hold so the block backs up and stalls its input
        if (results_seen == HOLD_AT)
          hold_left = HOLD_CYCLES;
        if (pending_answers.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result: expected none, actual status %0d count %0d",
                   $time, out_bus.status, out_bus.entry_count);
        end else begin
          want = pending_answers.pop_front();
          if (out_bus.status !== want.status) begin
            mismatch_count++;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, out_bus.status);
          end
          if (out_bus.entry_count !== want.entry_count) begin
            mismatch_count++;
            $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                     $time, want.entry_count, out_bus.entry_count);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (out_stall_left > 0) begin
        out_stall_left--;
        out_bus.ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        out_stall_left = $urandom_range(1, 6) - 1;
        out_bus.ready  <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_MAX) begin
        $display("%0t: no beat for %0d cycles", $time, idle_cycles);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic push_op(logic [OPCODE_W-1:0] opc, logic [IN_KEY_W-1:0] k,
                         logic [POS_W-1:0] p);
    op_queue.push_back({opc, k, p});
  endtask

  // waits until every item is taken and answered, then lets the row settle
  task automatic drain_block();
    while (op_queue.size() != 0 || pending_answers.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_sign_mode(bit v);
    @(posedge clk);
    cfg_bus.valid          <= 1'b1;
    cfg_bus.signed_compare <= v;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    sign_mode = v;
  endtask

  // alternating fill and drain runs over a small key pool plus random keys
  task automatic queue_random_phase(int n_items);
    logic [IN_KEY_W-1:0] pool [8];
    logic [OPCODE_W-1:0] opc;
    logic [IN_KEY_W-1:0] k;
    logic [POS_W-1:0]    p;
    int grow_pct;
    int pick;
    pool[0] = '0;
    pool[1] = '1;
    pool[2] = {1'b1, {(IN_KEY_W-1){1'b0}}};
    pool[3] = {1'b0, {(IN_KEY_W-1){1'b1}}};
    pool[4] = 32'd1;
    for (int i = 5; i < 8; i++)
      pool[i] = $urandom;
    for (int n = 0; n < n_items; n++) begin
      grow_pct = ((n / RUN_LENGTH) % 2 == 0) ? 80 : 20;
      pick = $urandom_range(0, 99);
      if (pick < grow_pct) begin
        case ($urandom_range(0, 4))
          0:       opc = OP_APPEND;
          1, 2:    opc = OP_INSERT;
          default: opc = OP_INSERT_UNQ;
        endcase
      end else if (pick < 97) begin
        opc = $urandom_range(0, 1) ? OP_DEL_KEY : OP_DEL_POS;
      end else begin
        opc = OPCODE_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      end
      k = $urandom_range(0, 1) ? pool[$urandom_range(0, 7)] : $urandom;
      p = $urandom_range(0, 1) ? POS_W'($urandom_range(0, 7))
                               : POS_W'($urandom_range(0, 31));
      push_op(opc, k, p);
    end
  endtask

  // stimulus and end of run
  initial begin
    rst_n                  = 1'b0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.signed_compare = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    write_sign_mode(1'b0);

    // empty table, spare opcodes, then order, duplicates and delete edges
    push_op(OP_DEL_KEY, '0, '0);
    push_op(OP_DEL_POS, '0, '0);
    push_op(OP_SPARE_FIRST, '0, '0);
    push_op(OP_SPARE_FIRST + 3'd1, 32'h5555_5555, 5'd10);
    push_op(OP_SPARE_LAST, '1, '1);
    push_op(OP_INSERT, 32'd5, '0);
    push_op(OP_INSERT, '0, '0);
    push_op(OP_INSERT, '1, '0);
    push_op(OP_INSERT, 32'd5, '0);
    push_op(OP_INSERT_UNQ, 32'd5, '0);
    push_op(OP_INSERT_UNQ, 32'd7, '0);
    push_op(OP_APPEND, 32'h8000_0000, '0);
    push_op(OP_INSERT, 32'h7FFF_FFFF, '0);
    push_op(OP_DEL_KEY, 32'd5, '0);
    push_op(OP_DEL_KEY, 32'd9, '0);
    push_op(OP_DEL_POS, '0, '1);
    push_op(OP_DEL_POS, '0, 5'd6);
    push_op(OP_DEL_POS, '0, 5'd5);
    push_op(OP_DEL_POS, '0, '0);
    push_op(OP_INSERT_UNQ, 32'h8000_0000, '0);
    drain_block();

    queue_random_phase(PHASE_ITEMS);
    drain_block();

    write_sign_mode(1'b1);
    queue_random_phase(PHASE_ITEMS);
    drain_block();

    write_sign_mode(1'b0);
    queue_random_phase(PHASE_ITEMS);
    drain_block();

    // last part runs back to back with no idling
    write_sign_mode(1'b1);
    quiet_tail = 1'b1;
    queue_random_phase(PHASE_ITEMS);
    drain_block();
    repeat (20) @(posedge clk);

    if (mismatch_count == 0 && pending_answers.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
